// ===== rtl/barl_pkg.sv =====
// Shared types and constants for the bounded address recency list.
// No dependencies; every other file in rtl/ imports this package.
package barl_pkg;

   localparam int ADDR_W     = 32;
   localparam int POS_W      = 4;
   localparam int LIMIT_W    = 4;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USED_W = 10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd6;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_ERASE  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_FULL = 1'b1
   } state_type;

   typedef struct packed {
      logic insert;
      logic find;
      logic erase;
      logic clear;
   } cmd_type;

endpackage

// ===== rtl/bounded_address_recency_list.sv =====
// Latency: a result word is valid in the cycle after its request is accepted.
// Throughput: one request word per cycle while the result side takes words;
//   the single result register holds a word until it is taken.
// Reset: clears the entry count and the result valid state, loads the limit with 6;
//   the address table is not cleared and needs no clearing pass.
// Depends on barl_pkg, barl_ctrl and barl_datapath.
module bounded_address_recency_list #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] address, [35:32] position, [39:36] zero
   input  logic [barl_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] op
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] evicted, [1] found, [5:2] match_position, [9:6] entry_count, [15:10] zero
   output logic [barl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [barl_pkg::LIMIT_W-1:0]        csr_data
);
   import barl_pkg::*;

   cmd_type               cmd;
   logic [RSP_USED_W-1:0] result;

   assign csr_ready = 1'b1;

   barl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (op_type'(req_tuser)),
      .rsp_tready (rsp_tready),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   barl_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .address   (req_tdata[ADDR_W-1:0]),
      .position  (req_tdata[ADDR_W+POS_W-1:ADDR_W]),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .result    (result)
   );

   assign rsp_tdata = {(RSP_DATA_W-RSP_USED_W)'(0), result};

endmodule

// ===== rtl/barl_ctrl.sv =====
// Handshake controller: owns the result word valid state and issues one
// decoded command per accepted request word. Depends on barl_pkg.
module barl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  barl_pkg::op_type  req_op,
   input  logic              rsp_tready,
   output logic              req_tready,
   output logic              rsp_tvalid,
   output barl_pkg::cmd_type cmd
);
   import barl_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE) || rsp_tready;
      rsp_tvalid = (state_ff == ST_FULL);
      accept     = req_tvalid && req_tready;
      cmd        = '0;
      state_in   = state_ff;
      if (accept) begin
         unique case (req_op)
            OP_INSERT: cmd.insert = 1'b1;
            OP_FIND:   cmd.find   = 1'b1;
            OP_ERASE:  cmd.erase  = 1'b1;
            OP_CLEAR:  cmd.clear  = 1'b1;
         endcase
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (!accept && rsp_tready) state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one command issued");
   a_cmd_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd != '0) |-> (req_tvalid && req_tready))
      else $error("command issued without accepted word");
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted word produced no result");
`endif

endmodule

// ===== rtl/barl_datapath.sv =====
// Address table (shift line with parallel compare), entry count, limit
// register and result register. Depends on barl_pkg.
module barl_datapath #(
   parameter int MAX_ENTRIES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  barl_pkg::cmd_type                 cmd,
   input  logic [barl_pkg::ADDR_W-1:0]       address,
   input  logic [barl_pkg::POS_W-1:0]        position,
   input  logic                              csr_write,
   input  logic [barl_pkg::LIMIT_W-1:0]      csr_data,
   output logic [barl_pkg::RSP_USED_W-1:0]   result
);
   import barl_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int WW = (CW > 4) ? CW : 4;
   localparam logic [WW-1:0] MAX_W = WW'(MAX_ENTRIES);

   logic [ADDR_W-1:0]     slot_ff [MAX_ENTRIES];
   logic [ADDR_W-1:0]     slot_in [MAX_ENTRIES];
   logic [CW-1:0]         count_ff, count_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [RSP_USED_W-1:0] result_ff, result_in;
   logic [WW-1:0]         count_w, limit_w, pos_w, eff_w, match_w, count_in_w;
   logic [MAX_ENTRIES-1:0] hit;
   logic                  found, over, any_cmd;

   always_comb begin
      count_w = WW'(count_ff);
      limit_w = WW'(limit_ff);
      pos_w   = WW'(position);
      eff_w   = (limit_w > MAX_W) ? MAX_W : limit_w;
      over    = ({1'b0, count_w} + 1'b1) > {1'b0, eff_w};
      any_cmd = cmd.insert || cmd.find || cmd.erase || cmd.clear;

      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit[i] = (slot_ff[i] == address) && (WW'(i) < count_w);
      end
      found   = 1'b0;
      match_w = eff_w;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found   = 1'b1;
            match_w = WW'(i);
         end
      end

      slot_in  = slot_ff;
      count_in = count_ff;
      limit_in = csr_write ? csr_data : limit_ff;
      if (cmd.insert) begin
         slot_in[0] = address;
         for (int i = 1; i < MAX_ENTRIES; i++) begin
            slot_in[i] = slot_ff[i-1];
         end
         if (!over) count_in = count_ff + 1'b1;
      end else if (cmd.erase) begin
         if (pos_w < count_w) begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
               if (WW'(i) >= pos_w) slot_in[i] = slot_ff[i+1];
            end
            count_in = count_ff - 1'b1;
         end
      end else if (cmd.clear) begin
         count_in = '0;
      end

      count_in_w = WW'(count_in);
      result_in = {count_in_w[3:0],
                   cmd.find ? match_w[3:0] : 4'd0,
                   cmd.find && found,
                   cmd.insert && over};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (any_cmd) result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

   assign result = result_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      WW'(count_ff) <= MAX_W)
      else $error("entry count above table depth");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0))
      else $error("clear left entries");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert && !over) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert below limit did not grow list");
   a_erase_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.erase && (pos_w < count_w)) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("erase in range did not shrink list");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for bounded_address_recency_list: random and directed list commands
// are checked against a built-in model of the address list. Needs barl_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import barl_pkg::*;

   localparam int MAX_SLOTS = 8;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [ADDR_W-1:0] address;
      op_type            op;
   } list_cmd_type;

   typedef struct packed {
      logic [3:0] entry_count;
      logic [3:0] match_position;
      logic       found;
      logic       evicted;
   } list_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [LIMIT_W-1:0]    csr_data = '0;

   list_cmd_type      pending_cmds[$];
   list_rsp_type      expected_rsps[$];
   list_cmd_type      cmd_on_bus;
   int                cmds_issued = 0;
   int                rsps_seen = 0;
   int                failures = 0;
   int                send_gap = 0;
   int                recv_stall = 0;
   bit                send_idle = 1'b1;
   bit                recv_idle = 1'b1;

   logic [ADDR_W-1:0]  list_slots[MAX_SLOTS];
   int                 list_count = 0;
   logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;
   logic [ADDR_W-1:0]  addr_pool[16];

   bounded_address_recency_list #(.MAX_ENTRIES(MAX_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_rsp_type apply_list_op(list_cmd_type c);
      list_rsp_type r;
      int           lim;
      int           n;
      r = '0;
      lim = (int'(limit_shadow) > MAX_SLOTS) ? MAX_SLOTS : int'(limit_shadow);
      case (c.op)
         OP_INSERT: begin
            n = (list_count < MAX_SLOTS) ? list_count : MAX_SLOTS - 1;
            for (int i = n; i > 0; i--) list_slots[i] = list_slots[i-1];
            list_slots[0] = c.address;
            if (list_count + 1 > lim) r.evicted = 1'b1;
            else list_count++;
         end
         OP_FIND: begin
            r.match_position = 4'(lim);
            for (int i = 0; i < list_count; i++) begin
               if (!r.found && list_slots[i] == c.address) begin
                  r.found = 1'b1;
                  r.match_position = 4'(i);
               end
            end
         end
         OP_ERASE: begin
            if (int'(c.position) < list_count) begin
               for (int i = int'(c.position); i + 1 < list_count; i++)
                  list_slots[i] = list_slots[i+1];
               list_count--;
            end
         end
         default: list_count = 0;
      endcase
      r.entry_count = 4'(list_count);
      return r;
   endfunction

   // request driver: hold a word until taken, then idle for the drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_rsps.push_back(apply_list_op(cmd_on_bus));
            send_gap = send_idle ? $urandom_range(0, 17) : 0;
         end
         if (send_gap == 0 && pending_cmds.size() > 0) begin
            cmd_on_bus = pending_cmds.pop_front();
            req_tdata  <= {4'b0, cmd_on_bus.position, cmd_on_bus.address};
            req_tuser  <= cmd_on_bus.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end
      end
   end

   // result monitor: compare each word with the oldest prediction
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[9:0];
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result word evicted=%0d found=%0d match=%0d count=%0d",
                        $time, got.evicted, got.found, got.match_position, got.entry_count);
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected evicted=%0d found=%0d match=%0d count=%0d",
                           $time, want.evicted, want.found, want.match_position,
                           want.entry_count);
                  $display("%0t:            actual evicted=%0d found=%0d match=%0d count=%0d",
                           $time, got.evicted, got.found, got.match_position,
                           got.entry_count);
                  failures++;
               end
            end
            recv_stall = recv_idle ? $urandom_range(0, 17) : 0;
         end
         if (recv_stall > 0) begin
            rsp_tready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_cmd(input op_type op, input logic [ADDR_W-1:0] addr,
                           input logic [POS_W-1:0] pos);
      list_cmd_type c;
      c.op = op;
      c.address = addr;
      c.position = pos;
      pending_cmds.push_back(c);
      cmds_issued++;
   endtask

   task automatic drain;
      do @(posedge clock); while (rsps_seen < cmds_issued);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_shadow = value;
   endtask

   task automatic push_random_cmd;
      int               k;
      op_type           op;
      logic [ADDR_W-1:0] addr;
      logic [POS_W-1:0]  pos;
      k = $urandom_range(0, 99);
      if (k < 45) op = OP_INSERT;
      else if (k < 78) op = OP_FIND;
      else if (k < 95) op = OP_ERASE;
      else op = OP_CLEAR;
      addr = ($urandom_range(0, 3) == 0) ? $urandom : addr_pool[$urandom_range(0, 15)];
      pos = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
      push_cmd(op, addr, pos);
   endtask

   initial begin
      logic [LIMIT_W-1:0] lim;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limit: duplicates, hits, a miss, erase in and out of range
      push_cmd(OP_INSERT, 32'h0000_0000, 4'd0);
      push_cmd(OP_INSERT, 32'hFFFF_FFFF, 4'd15);
      push_cmd(OP_INSERT, 32'h0A00_0001, 4'd0);
      push_cmd(OP_INSERT, 32'h0A00_0001, 4'd0);
      push_cmd(OP_FIND,   32'h0A00_0001, 4'd0);
      push_cmd(OP_FIND,   32'h0000_0000, 4'd0);
      push_cmd(OP_FIND,   32'h1234_5678, 4'd0);
      push_cmd(OP_ERASE,  32'h0000_0000, 4'd15);
      push_cmd(OP_ERASE,  32'hFFFF_FFFF, 4'd1);
      push_cmd(OP_ERASE,  32'h0000_0000, 4'd0);
      push_cmd(OP_CLEAR,  32'hFFFF_FFFF, 4'd15);
      drain();

      // zero limit: insert evicts at once
      write_limit(4'd0);
      push_cmd(OP_INSERT, 32'hC0A8_0101, 4'd0);
      push_cmd(OP_FIND,   32'hC0A8_0101, 4'd0);
      push_cmd(OP_ERASE,  32'h0000_0000, 4'd0);
      drain();

      // limit above table size saturates; fill and overflow
      write_limit(4'd15);
      for (int i = 0; i < 9; i++) push_cmd(OP_INSERT, 32'hC0A8_0000 + i, 4'd0);
      push_cmd(OP_FIND, 32'h0808_0808, 4'd0);
      drain();

      // limit lowered below the count: entries stay, hits past the limit
      write_limit(4'd2);
      push_cmd(OP_INSERT, 32'h7F00_0001, 4'd0);
      push_cmd(OP_FIND,   32'hC0A8_0004, 4'd0);
      push_cmd(OP_FIND,   32'h0808_0808, 4'd0);
      push_cmd(OP_CLEAR,  32'h0000_0000, 4'd0);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0) lim = 4'd1;
         else if (phase == 1) lim = 4'd8;
         else lim = 4'($urandom_range(0, 15));
         write_limit(lim);
         {send_idle, recv_idle} = 2'($urandom_range(0, 3));
         for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
         addr_pool[0] = 32'h0000_0000;
         addr_pool[1] = 32'hFFFF_FFFF;
         for (int i = 0; i < 75; i++) push_random_cmd();
         drain();
      end

      repeat (10) @(posedge clock);
      if (failures == 0 && expected_rsps.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
